[src/tlpw_pkg.sv]
// Shared types and constants for the two-level page table walker.
`timescale 1ns / 1ps

package tlpw_pkg;

    localparam int MEM_BYTES  = 4096;
    localparam int PAGE_BYTES = 32;
    localparam int ADDR_W     = $clog2(MEM_BYTES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = 5;
    localparam int NUM_W      = 7;
    localparam int VA_W       = 15;
    localparam int BYTE_W     = 8;
    localparam int PADDR_W    = 3;

    localparam logic [BYTE_W-1:0] VALID_BIT_MASK = 8'h80;

    localparam logic [1:0] KIND_STORE_MEM  = 2'd0;
    localparam logic [1:0] KIND_STORE_DISK = 2'd1;
    localparam logic [1:0] KIND_TRANSLATE  = 2'd2;

    localparam logic [1:0] STATUS_MEMORY    = 2'd0;
    localparam logic [1:0] STATUS_DISK      = 2'd1;
    localparam logic [1:0] STATUS_DIR_FAULT = 2'd2;

    localparam logic [0:0]        REG_DIRECTORY_BASE = 1'b0;
    localparam logic [ADDR_W-1:0] DIR_BASE_RESET     = 12'hd80;

    typedef struct packed {
        logic              rd_en;
        logic              rd_disk;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_mem;
        logic              wr_disk;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  dir_index;
        logic              dir_valid;
        logic [NUM_W-1:0]  table_page;
        logic [IDX_W-1:0]  table_index;
        logic              table_valid;
        logic [NUM_W-1:0]  frame_number;
        logic [ADDR_W-1:0] phys_addr;
        logic [BYTE_W-1:0] data_value;
    } result_t;

endpackage

[src/tlpw_store.sv]
// Byte-wide main memory and disk image, one registered read per cycle.
`timescale 1ns / 1ps

module tlpw_store
    import tlpw_pkg::*;
(
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] main_mem [MEM_BYTES];
    logic [BYTE_W-1:0] disk_mem [MEM_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_mem) begin
            main_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.wr_disk) begin
            disk_mem[req.wr_addr] <= req.wr_data;
        end
    end

    // The read data holds until the next read, so a stalled walk keeps its byte.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            if (req.rd_disk) begin
                rd_data_reg <= disk_mem[req.rd_addr];
            end else begin
                rd_data_reg <= main_mem[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/tlpw_ctrl.sv]
// Walk sequencer with the shared address adder and the result register.
`timescale 1ns / 1ps

module tlpw_ctrl
    import tlpw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [ADDR_W-1:0] dir_base,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_kind,
    input  logic [ADDR_W-1:0] s_store_address,
    input  logic [BYTE_W-1:0] s_store_byte,
    input  logic [VA_W-1:0]   s_virtual_address,
    output mem_req_t          mem_req,
    input  logic [BYTE_W-1:0] mem_rd_data,
    output logic              m_valid,
    input  logic              m_ready,
    output result_t           m_result
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIR  = 4'b0010,
        ST_TBL  = 4'b0100,
        ST_DATA = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  ti_reg, ti_next;
    logic [IDX_W-1:0]  di_reg, di_next;
    logic [IDX_W-1:0]  off_reg, off_next;
    logic [NUM_W-1:0]  tpage_reg, tpage_next;
    logic [NUM_W-1:0]  frame_reg, frame_next;
    logic              tvalid_reg, tvalid_next;
    logic [ADDR_W-1:0] pa_reg, pa_next;
    logic              m_valid_reg, m_valid_next;
    result_t           result_reg, result_next;

    logic              accept;
    logic              out_free;
    logic [ADDR_W-1:0] agu_a;
    logic [ADDR_W-1:0] agu_b;
    logic [ADDR_W-1:0] agu_sum;
    logic              entry_valid;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign entry_valid = (mem_rd_data & VALID_BIT_MASK) != '0;

    // One adder forms every walk address; the sum wraps at the memory size.
    always_comb begin
        unique case (state_reg)
            ST_IDLE: begin
                agu_a = dir_base;
                agu_b = ADDR_W'(s_virtual_address[VA_W-1 -: IDX_W]);
            end
            ST_DIR: begin
                agu_a = ADDR_W'(ADDR_W'(mem_rd_data[NUM_W-1:0]) << PAGE_SHIFT);
                agu_b = ADDR_W'(ti_reg);
            end
            ST_TBL: begin
                agu_a = ADDR_W'(ADDR_W'(mem_rd_data[NUM_W-1:0]) << PAGE_SHIFT);
                agu_b = ADDR_W'(off_reg);
            end
            default: begin
                agu_a = '0;
                agu_b = '0;
            end
        endcase
    end

    assign agu_sum = agu_a + agu_b;

    always_comb begin
        state_next   = state_reg;
        di_next      = di_reg;
        ti_next      = ti_reg;
        off_next     = off_reg;
        tpage_next   = tpage_reg;
        frame_next   = frame_reg;
        tvalid_next  = tvalid_reg;
        pa_next      = pa_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg && !m_ready;

        mem_req         = '0;
        mem_req.rd_addr = agu_sum;
        mem_req.wr_addr = s_store_address;
        mem_req.wr_data = s_store_byte;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_STORE_MEM:  mem_req.wr_mem = 1'b1;
                        KIND_STORE_DISK: mem_req.wr_disk = 1'b1;
                        KIND_TRANSLATE: begin
                            mem_req.rd_en = 1'b1;
                            di_next       = s_virtual_address[VA_W-1 -: IDX_W];
                            ti_next       = s_virtual_address[2*IDX_W-1 -: IDX_W];
                            off_next      = s_virtual_address[IDX_W-1:0];
                            state_next    = ST_DIR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIR: begin
                if (!entry_valid) begin
                    if (out_free) begin
                        result_next           = '0;
                        result_next.status    = STATUS_DIR_FAULT;
                        result_next.dir_index = di_reg;
                        m_valid_next          = 1'b1;
                        state_next            = ST_IDLE;
                    end
                end else begin
                    tpage_next    = mem_rd_data[NUM_W-1:0];
                    mem_req.rd_en = 1'b1;
                    state_next    = ST_TBL;
                end
            end
            ST_TBL: begin
                frame_next      = mem_rd_data[NUM_W-1:0];
                tvalid_next     = entry_valid;
                pa_next         = agu_sum;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_disk = !entry_valid;
                state_next      = ST_DATA;
            end
            ST_DATA: begin
                if (out_free) begin
                    result_next.status       = tvalid_reg ? STATUS_MEMORY : STATUS_DISK;
                    result_next.dir_index    = di_reg;
                    result_next.dir_valid    = 1'b1;
                    result_next.table_page   = tpage_reg;
                    result_next.table_index  = ti_reg;
                    result_next.table_valid  = tvalid_reg;
                    result_next.frame_number = frame_reg;
                    result_next.phys_addr    = pa_reg;
                    result_next.data_value   = mem_rd_data;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        di_reg     <= di_next;
        ti_reg     <= ti_next;
        off_reg    <= off_next;
        tpage_reg  <= tpage_next;
        frame_reg  <= frame_next;
        tvalid_reg <= tvalid_next;
        pa_reg     <= pa_next;
        result_reg <= result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("input accepted outside the idle state");

    a_translate_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_kind == KIND_TRANSLATE) |=> state_reg == ST_DIR)
        else $error("translate item did not start a walk");

    a_fault_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.status == STATUS_DIR_FAULT) |->
        (result_reg.dir_valid == 1'b0 && result_reg.data_value == '0 &&
         result_reg.phys_addr == '0 && result_reg.table_valid == 1'b0))
        else $error("directory fault carries walk fields");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DIR || $past(state_reg) == ST_DATA))
        else $error("result raised outside a walk end");

endmodule

[src/two_level_page_walk.sv]
// Store items give no result; they are accepted back to back.
// A translate item returns its result after the directory read on a directory fault,
// and after the data read on a full walk; the walker then returns to idle for the next item.
// A full walk makes three dependent reads through one registered memory port.
// Reset is synchronous and active low; memory and disk contents stay undefined until written.
`timescale 1ns / 1ps

module two_level_page_walk
    import tlpw_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [ADDR_W-1:0]  s_store_address,
    input  logic [BYTE_W-1:0]  s_store_byte,
    input  logic [VA_W-1:0]    s_virtual_address,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [IDX_W-1:0]   m_dir_index,
    output logic               m_dir_valid,
    output logic [NUM_W-1:0]   m_table_page,
    output logic [IDX_W-1:0]   m_table_index,
    output logic               m_table_valid,
    output logic [NUM_W-1:0]   m_frame_number,
    output logic [ADDR_W-1:0]  m_phys_addr,
    output logic [BYTE_W-1:0]  m_data_value
);

    logic [ADDR_W-1:0] dir_base_reg, dir_base_next;
    logic              reg_hit;
    mem_req_t          mem_req;
    logic [BYTE_W-1:0] mem_rd_data;
    result_t           result;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1 -: 1] == REG_DIRECTORY_BASE);

    always_comb begin
        dir_base_next = dir_base_reg;
        if (psel && penable && pwrite && reg_hit) begin
            dir_base_next = pwdata[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_base_reg <= DIR_BASE_RESET;
        end else begin
            dir_base_reg <= dir_base_next;
        end
    end

    assign prdata = reg_hit ? 32'(dir_base_reg) : '0;

    tlpw_ctrl u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .dir_base          (dir_base_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_store_address   (s_store_address),
        .s_store_byte      (s_store_byte),
        .s_virtual_address (s_virtual_address),
        .mem_req           (mem_req),
        .mem_rd_data       (mem_rd_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result          (result)
    );

    tlpw_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign m_status       = result.status;
    assign m_dir_index    = result.dir_index;
    assign m_dir_valid    = result.dir_valid;
    assign m_table_page   = result.table_page;
    assign m_table_index  = result.table_index;
    assign m_table_valid  = result.table_valid;
    assign m_frame_number = result.frame_number;
    assign m_phys_addr    = result.phys_addr;
    assign m_data_value   = result.data_value;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the two-level page table walker.
`timescale 1ns / 1ps

module tb_top
    import tlpw_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam int         PHASE_ITEMS    = 80;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         REPORT_LIMIT   = 10;

    typedef enum logic [1:0] {
        WALK_OK,
        MISS_DIRECTORY,
        MISS_TABLE,
        MISS_DATA
    } walk_miss_t;

    typedef struct packed {
        bit                cfg;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic [VA_W-1:0]   va;
        bit                typed;
        result_t           res;
    } directed_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_kind = '0;
    logic [ADDR_W-1:0]  s_store_address = '0;
    logic [BYTE_W-1:0]  s_store_byte = '0;
    logic [VA_W-1:0]    s_virtual_address = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [IDX_W-1:0]   m_dir_index;
    logic               m_dir_valid;
    logic [NUM_W-1:0]   m_table_page;
    logic [IDX_W-1:0]   m_table_index;
    logic               m_table_valid;
    logic [NUM_W-1:0]   m_frame_number;
    logic [ADDR_W-1:0]  m_phys_addr;
    logic [BYTE_W-1:0]  m_data_value;

    // Shadow of the block: both byte stores, which entries hold a written
    // value, and the directory base.
    logic [BYTE_W-1:0] main_mem [MEM_BYTES];
    logic [BYTE_W-1:0] disk_img [MEM_BYTES];
    bit                mem_written [MEM_BYTES];
    bit                disk_written [MEM_BYTES];
    logic [ADDR_W-1:0] dir_base = DIR_BASE_RESET;

    result_t expected_walks [$];
    int      error_count = 0;
    int      idle_cycles = 0;
    int      next_gap = 0;
    int      tx_burst = 0;
    int      rx_burst = 0;
    int      rx_hold = 0;

    directed_row_t directed_rows [21] = '{
        '{1'b0, KIND_STORE_MEM,  12'hd80, 8'h00, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_TRANSLATE,  12'h000, 8'h00, 15'h0000, 1'b1,
          '{STATUS_DIR_FAULT, 5'd0, 1'b0, 7'd0, 5'd0, 1'b0, 7'd0, 12'h000, 8'h00}},
        '{1'b0, KIND_STORE_MEM,  12'hd9f, 8'h85, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_STORE_MEM,  12'h0bf, 8'h7f, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_STORE_DISK, 12'hfff, 8'hff, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_TRANSLATE,  12'h000, 8'h00, 15'h7fff, 1'b1,
          '{STATUS_DISK, 5'd31, 1'b1, 7'd5, 5'd31, 1'b0, 7'd127, 12'hfff, 8'hff}},
        '{1'b0, KIND_STORE_MEM,  12'hd81, 8'h80, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_STORE_MEM,  12'h000, 8'h80, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_TRANSLATE,  12'h000, 8'h00, 15'h0400, 1'b0, '0},
        '{1'b0, KIND_STORE_MEM,  12'hd82, 8'hff, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_STORE_MEM,  12'hfe2, 8'hff, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_STORE_MEM,  12'hfff, 8'h00, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_TRANSLATE,  12'h000, 8'h00, 15'h085f, 1'b0, '0},
        '{1'b1, KIND_STORE_MEM,  12'hfff, 8'h00, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_STORE_MEM,  12'h005, 8'h5a, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_TRANSLATE,  12'h000, 8'h00, 15'h0405, 1'b1,
          '{STATUS_MEMORY, 5'd1, 1'b1, 7'd0, 5'd0, 1'b1, 7'd0, 12'h005, 8'h5a}},
        '{1'b0, KIND_UNUSED,     12'h005, 8'h00, 15'h7fff, 1'b0, '0},
        '{1'b0, KIND_TRANSLATE,  12'h000, 8'h00, 15'h0405, 1'b0, '0},
        '{1'b0, KIND_TRANSLATE,  12'h000, 8'h00, 15'h03ff, 1'b1,
          '{STATUS_DIR_FAULT, 5'd0, 1'b0, 7'd0, 5'd0, 1'b0, 7'd0, 12'h000, 8'h00}},
        '{1'b1, KIND_STORE_MEM,  12'h000, 8'h00, 15'h0000, 1'b0, '0},
        '{1'b0, KIND_TRANSLATE,  12'h000, 8'h00, 15'h0005, 1'b0, '0}
    };

    two_level_page_walk DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_store_address   (s_store_address),
        .s_store_byte      (s_store_byte),
        .s_virtual_address (s_virtual_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_dir_index       (m_dir_index),
        .m_dir_valid       (m_dir_valid),
        .m_table_page      (m_table_page),
        .m_table_index     (m_table_index),
        .m_table_valid     (m_table_valid),
        .m_frame_number    (m_frame_number),
        .m_phys_addr       (m_phys_addr),
        .m_data_value      (m_data_value)
    );

    always #2 aclk = ~aclk;

    // Walks the two tables for one virtual address. Where the walk would read
    // an entry that holds no written value, it stops and names that entry.
    function automatic walk_miss_t translate_walk(input logic [VA_W-1:0] va,
                                                  output result_t res,
                                                  output logic miss_disk,
                                                  output logic [ADDR_W-1:0] miss_addr);
        logic [IDX_W-1:0]      di;
        logic [IDX_W-1:0]      ti;
        logic [PAGE_SHIFT-1:0] offset;
        logic [ADDR_W-1:0]     a;
        logic [BYTE_W-1:0]     entry;
        di = va[VA_W-1 -: IDX_W];
        ti = va[PAGE_SHIFT +: IDX_W];
        offset = va[PAGE_SHIFT-1:0];
        res = '0;
        miss_disk = 1'b0;
        miss_addr = '0;
        res.dir_index = di;
        a = dir_base + ADDR_W'(di);
        miss_addr = a;
        if (!mem_written[a]) return MISS_DIRECTORY;
        entry = main_mem[a];
        if ((entry & VALID_BIT_MASK) == '0) begin
            res.status = STATUS_DIR_FAULT;
            return WALK_OK;
        end
        res.dir_valid = 1'b1;
        res.table_page = entry[NUM_W-1:0];
        res.table_index = ti;
        a = (ADDR_W'(res.table_page) << PAGE_SHIFT) + ADDR_W'(ti);
        miss_addr = a;
        if (!mem_written[a]) return MISS_TABLE;
        entry = main_mem[a];
        res.frame_number = entry[NUM_W-1:0];
        a = (ADDR_W'(res.frame_number) << PAGE_SHIFT) + ADDR_W'(offset);
        res.phys_addr = a;
        miss_addr = a;
        if ((entry & VALID_BIT_MASK) != '0) begin
            res.status = STATUS_MEMORY;
            res.table_valid = 1'b1;
            if (!mem_written[a]) return MISS_DATA;
            res.data_value = main_mem[a];
        end else begin
            res.status = STATUS_DISK;
            miss_disk = 1'b1;
            if (!disk_written[a]) return MISS_DATA;
            res.data_value = disk_img[a];
        end
        return WALK_OK;
    endfunction

    // Runs of zero wait are drawn now and then, so that long stretches go
    // without any idling.
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst = burst - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 32);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Mostly a few low values, so that later walks reuse entries already built.
    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, 3));
        return IDX_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [NUM_W-1:0] pick_number();
        case ($urandom_range(0, 8))
            0:       return 7'd0;
            1:       return 7'd127;
            2, 3:    return 7'd3;
            4, 5:    return 7'd42;
            6, 7:    return 7'd100;
            default: return NUM_W'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic send(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                        input logic [BYTE_W-1:0] data, input logic [VA_W-1:0] va,
                        input bit use_typed, input result_t typed);
        result_t    walk;
        logic       miss_disk;
        logic [ADDR_W-1:0] miss_addr;
        repeat (next_gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_kind <= kind;
        s_store_address <= addr;
        s_store_byte <= data;
        s_virtual_address <= va;
        do @(posedge aclk); while (!s_ready);
        if (use_typed) begin
            expected_walks.push_back(typed);
        end else begin
            case (kind)
                KIND_STORE_MEM: begin
                    main_mem[addr] = data;
                    mem_written[addr] = 1'b1;
                end
                KIND_STORE_DISK: begin
                    disk_img[addr] = data;
                    disk_written[addr] = 1'b1;
                end
                KIND_TRANSLATE: begin
                    void'(translate_walk(va, walk, miss_disk, miss_addr));
                    expected_walks.push_back(walk);
                end
                default: ;
            endcase
        end
        // valid stays high only when the next item follows in this very step.
        next_gap = draw_wait(tx_burst);
        if (next_gap != 0) s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        if (next_gap == 0) begin
            s_valid <= 1'b0;
            next_gap = 1;
        end
        while (expected_walks.size() != 0) @(posedge aclk);
    endtask

    task automatic set_directory_base(input logic [ADDR_W-1:0] value);
        drain_results();
        // Store items leave no result behind, so allow the pipeline to settle.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({REG_DIRECTORY_BASE, 2'b00});
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        dir_base = value;
    endtask

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        bit      bad;
        int      hold;
        if (!aresetn) begin
            m_ready <= 1'b1;
            rx_hold <= 0;
        end else if (m_valid && m_ready) begin
            got = {m_status, m_dir_index, m_dir_valid, m_table_page, m_table_index,
                   m_table_valid, m_frame_number, m_phys_addr, m_data_value};
            if (expected_walks.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("walk result error: result arrived with none expected");
            end else begin
                want = expected_walks.pop_front();
                bad = (got.status !== want.status) || (got.dir_index !== want.dir_index)
                    || (got.dir_valid !== want.dir_valid)
                    || (got.table_page !== want.table_page)
                    || (got.table_index !== want.table_index)
                    || (got.table_valid !== want.table_valid)
                    || (got.frame_number !== want.frame_number)
                    || (got.phys_addr !== want.phys_addr)
                    || (got.data_value !== want.data_value);
                if (bad) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("walk result error:");
                        $write("  expected st %0d di %0d dv %0d tp %0d ti %0d",
                               want.status, want.dir_index, want.dir_valid,
                               want.table_page, want.table_index);
                        $display(" tv %0d fn %0d pa %h data %h",
                                 want.table_valid, want.frame_number, want.phys_addr,
                                 want.data_value);
                        $write("  actual   st %0d di %0d dv %0d tp %0d ti %0d",
                               got.status, got.dir_index, got.dir_valid,
                               got.table_page, got.table_index);
                        $display(" tv %0d fn %0d pa %h data %h",
                                 got.table_valid, got.frame_number, got.phys_addr,
                                 got.data_value);
                    end
                end
            end
            hold = draw_wait(rx_burst);
            rx_hold <= hold;
            if (hold != 0) m_ready <= 1'b0;
        end else if (!m_ready) begin
            if (rx_hold <= 1) m_ready <= 1'b1;
            rx_hold <= rx_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        result_t           blank;
        result_t           probe;
        walk_miss_t        miss;
        logic              miss_disk;
        logic [ADDR_W-1:0] miss_addr;
        logic [ADDR_W-1:0] base_value;
        logic [BYTE_W-1:0] fill_byte;
        logic [VA_W-1:0]   pending_va;
        bit                have_pending;
        int                phase;
        int                sent;
        int                roll;
        blank = '0;
        have_pending = 1'b0;
        pending_va = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg)
                set_directory_base(directed_rows[i].addr);
            else
                send(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].data,
                     directed_rows[i].va, directed_rows[i].typed, directed_rows[i].res);
        end

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       base_value = '0;
                1:       base_value = '1;
                4:       base_value = DIR_BASE_RESET;
                default: base_value = ADDR_W'($urandom_range(0, MEM_BYTES - 1));
            endcase
            set_directory_base(base_value);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (phase == 2 && sent == PHASE_ITEMS / 2) drain_results();
                if (!have_pending) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 55) begin
                        pending_va = {pick_index(), pick_index(), pick_index()};
                        have_pending = 1'b1;
                    end else if (roll < 62) begin
                        pending_va = VA_W'($urandom_range(0, (1 << VA_W) - 1));
                        have_pending = 1'b1;
                    end else if (roll < 76) begin
                        send(KIND_STORE_MEM, ADDR_W'($urandom_range(0, MEM_BYTES - 1)),
                             BYTE_W'($urandom_range(0, 255)),
                             VA_W'($urandom_range(0, (1 << VA_W) - 1)), 1'b0, blank);
                        sent++;
                    end else if (roll < 90) begin
                        send(KIND_STORE_DISK, ADDR_W'($urandom_range(0, MEM_BYTES - 1)),
                             BYTE_W'($urandom_range(0, 255)),
                             VA_W'($urandom_range(0, (1 << VA_W) - 1)), 1'b0, blank);
                        sent++;
                    end else begin
                        send(KIND_UNUSED, ADDR_W'($urandom_range(0, MEM_BYTES - 1)),
                             BYTE_W'($urandom_range(0, 255)),
                             VA_W'($urandom_range(0, (1 << VA_W) - 1)), 1'b0, blank);
                    end
                end
                // A translation goes out only once every entry on its walk has
                // been written; until then each item fills in the next gap.
                if (have_pending) begin
                    miss = translate_walk(pending_va, probe, miss_disk, miss_addr);
                    if (miss == WALK_OK) begin
                        send(KIND_TRANSLATE, ADDR_W'($urandom_range(0, MEM_BYTES - 1)),
                             BYTE_W'($urandom_range(0, 255)), pending_va, 1'b0, blank);
                        have_pending = 1'b0;
                    end else begin
                        case (miss)
                            MISS_DIRECTORY:
                                fill_byte = {($urandom_range(0, 3) != 0), pick_number()};
                            MISS_TABLE:
                                fill_byte = {($urandom_range(0, 4) >= 2), pick_number()};
                            default:
                                fill_byte = BYTE_W'($urandom_range(0, 255));
                        endcase
                        send(miss_disk ? KIND_STORE_DISK : KIND_STORE_MEM, miss_addr,
                             fill_byte, VA_W'($urandom_range(0, (1 << VA_W) - 1)),
                             1'b0, blank);
                    end
                    sent++;
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
